/* sv/tsss_pkg.sv */
// shared types, constants and time conversion for the timed stage switch scheduler
package tsss_pkg;

	localparam int unsigned TIME_W      = 14;
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned CNT_W       = 5;
	localparam logic [15:0] TIME_NONE   = 16'hFFFF;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_LOAD  = 1'b1;
	localparam logic EV_OPEN  = 1'b0;
	localparam logic EV_CLOSE = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] start_min;
		logic [TIME_W-1:0] end_min;
		logic [15:0]       groups;
		logic [15:0]       loops;
		logic              valid;
	} rec_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  stage;
		logic [15:0] loops;
		logic [15:0] groups;
		logic        supp;
		logic        last;
	} event_t;

	// hour byte * 60 + minute byte
	function automatic logic [TIME_W-1:0] to_min(input logic [15:0] w);
		return TIME_W'(w[15:8]) * TIME_W'(60) + TIME_W'(w[7:0]);
	endfunction

	function automatic logic is_near(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d < TIME_W'(2);
	endfunction

endpackage

/* sv/tsss_mem.sv */
// stage record memory, one write port and one registered read port
module tsss_mem import tsss_pkg::*; #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rec_t          wr_data,
	input  logic [AW-1:0] rd_addr,
	output rec_t          rd_data
);

	rec_t             mem [DEPTH];
	rec_t             rd_raw_s1;
	logic             rd_written_s1;
	logic [DEPTH-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_s1 <= written_q[rd_addr];
		end
	end

	// entries never loaded read as the cleared record
	assign rd_data = rd_written_s1 ? rd_raw_s1 : '0;

endmodule

/* sv/timed_stage_switch_scheduler_core.sv */
// timed stage switch scheduler: load and tick control around the stage record memory
// a load only writes the memory; a tick walks the stages one at a time through the memory port
// per tick: S_RD and S_EVAL per stage, S_OPEN per open, S_SCAN_RD and S_SCAN over every stage
// then S_CLOSE per close, S_FLUSH to finish, plus output stalls; the input stalls until idle
// each result of a tick is held back until the next one is known; the final one is marked last
// reset clears control, done flags and the loaded marks; unloaded stages read as zero
module timed_stage_switch_scheduler_core import tsss_pkg::*; #(
	parameter int unsigned STAGES     = 8,
	parameter int unsigned GROUP_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [2:0]  stage_index,
	input  logic [15:0] start_time,
	input  logic [15:0] end_time,
	input  logic [15:0] group_mask,
	input  logic [15:0] loop_mask,
	input  logic [4:0]  now_hour,
	input  logic [5:0]  now_minute,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_kind,
	output logic [2:0]  event_stage,
	output logic [15:0] event_loops,
	output logic [15:0] event_groups,
	output logic        close_suppressed,
	output logic        last_event
);

	localparam int unsigned AW   = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [AW-1:0] LAST = AW'(STAGES - 1);
	localparam logic [15:0] GMASK = 16'((32'd1 << GROUP_BITS) - 32'd1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_RD      = 8'b0000_0010,
		S_EVAL    = 8'b0000_0100,
		S_OPEN    = 8'b0000_1000,
		S_SCAN_RD = 8'b0001_0000,
		S_SCAN    = 8'b0010_0000,
		S_CLOSE   = 8'b0100_0000,
		S_FLUSH   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] end_i_q;
	logic [15:0]       groups_i_q;
	logic [15:0]       loops_i_q;
	logic              close_fire_q;
	logic [15:0]       acc_groups_q;
	logic              acc_supp_q;
	logic [STAGES-1:0] open_done_q;
	logic [STAGES-1:0] close_done_q;
	logic [CNT_W-1:0]  cnt_q;
	event_t            pend_q;
	logic              pend_valid_q;
	event_t            out_q;
	logic              out_valid_q;

	rec_t          rd_data;
	rec_t          wr_data;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic          accept;
	logic          out_free;
	logic          open_match;
	logic          close_match;
	logic          other;
	logic          near;
	logic          emitting;
	logic          drop;
	logic          push;
	logic          flush_out;
	event_t        cand;
	event_t        flush_ev;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign wr_en = accept && (operation == OP_LOAD) && ({2'b00, stage_index} < 5'(STAGES));
	always_comb begin
		wr_data.start_min = to_min(start_time);
		wr_data.end_min   = to_min(end_time);
		wr_data.groups    = group_mask;
		wr_data.loops     = loop_mask;
		wr_data.valid     = !(((start_time == '0) && (end_time == '0)) ||
			(start_time == TIME_NONE) || (end_time == TIME_NONE));
	end

	assign rd_addr = (state_q == S_RD) ? i_q : j_q;

	tsss_mem #(
		.DEPTH (STAGES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (AW'(stage_index)),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign open_match  = (now_q == rd_data.start_min);
	assign close_match = (now_q == rd_data.end_min);
	assign other       = (j_q != i_q);
	assign near        = is_near(rd_data.start_min, end_i_q);

	assign emitting  = (state_q == S_OPEN) || (state_q == S_CLOSE);
	assign drop      = (cnt_q >= CNT_W'(MAX_RESULTS));
	assign push      = emitting && !drop && (!pend_valid_q || out_free);
	assign flush_out = (state_q == S_FLUSH) && pend_valid_q && out_free;

	always_comb begin
		cand.kind   = (state_q == S_CLOSE) ? EV_CLOSE : EV_OPEN;
		cand.stage  = 3'(i_q);
		cand.loops  = loops_i_q;
		cand.groups = (state_q == S_CLOSE) ? acc_groups_q : groups_i_q;
		cand.supp   = (state_q == S_CLOSE) ? acc_supp_q : 1'b0;
		cand.last   = 1'b0;
	end

	always_comb begin
		flush_ev      = pend_q;
		flush_ev.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			open_done_q  <= '0;
			close_done_q <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			close_fire_q <= 1'b0;
		end else begin
			out_valid_q <= (push && pend_valid_q) || flush_out || !out_free;
			case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_TICK)) begin
						i_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!rd_data.valid) begin
						if (i_q == LAST) begin
							state_q <= S_FLUSH;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RD;
						end
					end else begin
						open_done_q[i_q]  <= open_match;
						close_done_q[i_q] <= close_match;
						close_fire_q      <= close_match && !close_done_q[i_q];
						j_q               <= '0;
						if (open_match && !open_done_q[i_q]) begin
							state_q <= S_OPEN;
						end else if (close_match && !close_done_q[i_q]) begin
							state_q <= S_SCAN_RD;
						end else if (i_q == LAST) begin
							state_q <= S_FLUSH;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_OPEN: begin
					if (drop || push) begin
						if (close_fire_q) begin
							state_q <= S_SCAN_RD;
						end else if (i_q == LAST) begin
							state_q <= S_FLUSH;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (j_q == LAST) begin
						state_q <= S_CLOSE;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_CLOSE: begin
					if (drop || push) begin
						if (i_q == LAST) begin
							state_q <= S_FLUSH;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (push) begin
				cnt_q        <= cnt_q + CNT_W'(1);
				pend_valid_q <= 1'b1;
			end
		end
	end

	// tick time, record of the stage under work, close accumulators and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= TIME_W'(now_hour) * TIME_W'(60) + TIME_W'(now_minute);
		end
		if (state_q == S_EVAL) begin
			end_i_q      <= rd_data.end_min;
			groups_i_q   <= rd_data.groups;
			loops_i_q    <= rd_data.loops;
			acc_groups_q <= rd_data.groups;
			acc_supp_q   <= 1'b0;
		end
		if (state_q == S_SCAN && other && near) begin
			if (groups_i_q == '0) begin
				if (rd_data.groups == '0) begin
					acc_supp_q <= 1'b1;
				end
			end else if (rd_data.groups != '0) begin
				acc_groups_q <= acc_groups_q & ~(rd_data.groups & GMASK);
			end
		end
		if (push) begin
			pend_q <= cand;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end
		if (flush_out) begin
			out_q <= flush_ev;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_kind       = out_q.kind;
	assign event_stage      = out_q.stage;
	assign event_loops      = out_q.loops;
	assign event_groups     = out_q.groups;
	assign close_suppressed = out_q.supp;
	assign last_event       = out_q.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count beyond limit");

	a_pend_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held result left behind at idle");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_LOAD)) |=> (state_q == S_IDLE) && !$rose(out_valid_q))
		else $error("load transfer started work or produced a result");

	a_open_no_supp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind == EV_OPEN)) |-> !out_q.supp)
		else $error("open event flagged suppressed");

endmodule
